// File: hw/rtl/c8x_pkg.sv
// ----------------------------------------------------------------------------
// c8x_pkg
// Shared types, constants and the font table of the CHIP-8 execute core.
// ----------------------------------------------------------------------------
package c8x_pkg;

  localparam int unsigned MEM_BYTES       = 4096;
  localparam int unsigned ADDR_W          = 12;
  localparam int unsigned SCREEN_W        = 64;
  localparam int unsigned SCREEN_H        = 32;
  localparam int unsigned ROW_W           = 5;
  localparam int unsigned NUM_VREGS       = 16;
  localparam int unsigned STACK_DEPTH_DEF = 16;
  localparam int unsigned FONT_BYTES      = 80;

  localparam logic [ADDR_W-1:0] FONT_BASE      = 12'h050;
  localparam logic [ADDR_W-1:0] PROG_START_RST = 12'h200;
  localparam logic [ADDR_W-1:0] PC_STEP        = 12'd2;

  localparam logic [11:0] SYS_CLS = 12'h0E0;
  localparam logic [11:0] SYS_RET = 12'h0EE;

  localparam logic [3:0] ALU_LD  = 4'h0;
  localparam logic [3:0] ALU_OR  = 4'h1;
  localparam logic [3:0] ALU_AND = 4'h2;
  localparam logic [3:0] ALU_XOR = 4'h3;
  localparam logic [3:0] ALU_ADD = 4'h4;
  localparam logic [3:0] ALU_SUB = 4'h5;
  localparam logic [3:0] ALU_SHR = 4'h6;
  localparam logic [3:0] ALU_SBN = 4'h7;
  localparam logic [3:0] ALU_SHL = 4'hE;

  localparam logic [7:0] KEY_SKP  = 8'h9E;
  localparam logic [7:0] KEY_SKNP = 8'hA1;

  localparam logic [7:0] FX_LDDT  = 8'h07;
  localparam logic [7:0] FX_WKEY  = 8'h0A;
  localparam logic [7:0] FX_SETDT = 8'h15;
  localparam logic [7:0] FX_SETST = 8'h18;
  localparam logic [7:0] FX_ADDI  = 8'h1E;
  localparam logic [7:0] FX_FONT  = 8'h29;
  localparam logic [7:0] FX_BCD   = 8'h33;
  localparam logic [7:0] FX_STORE = 8'h55;
  localparam logic [7:0] FX_LOAD  = 8'h65;

  typedef enum logic [2:0] {
    ITEM_EXEC  = 3'd0,
    ITEM_WRITE = 3'd1,
    ITEM_READ  = 3'd2,
    ITEM_ROW   = 3'd3,
    ITEM_TICK  = 3'd4
  } item_e;

  typedef enum logic [3:0] {
    OP_SYS  = 4'h0, OP_JP   = 4'h1, OP_CALL = 4'h2, OP_SE   = 4'h3,
    OP_SNE  = 4'h4, OP_SER  = 4'h5, OP_LD   = 4'h6, OP_ADD  = 4'h7,
    OP_ALU  = 4'h8, OP_SNER = 4'h9, OP_LDI  = 4'hA, OP_JPV  = 4'hB,
    OP_RND  = 4'hC, OP_DRW  = 4'hD, OP_KEY  = 4'hE, OP_MISC = 4'hF
  } op_e;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_ITEM, ST_MEM_CAP, ST_RDX, ST_RDY, ST_EXEC, ST_CLS,
    ST_DRAW_RD, ST_DRAW_WR, ST_DRAW_FLAG, ST_BCD, ST_STORE, ST_LOAD_RD,
    ST_LOAD_WR, ST_DONE
  } st_e;

  typedef enum logic [4:0] {
    CMD_NONE, CMD_CLEAR, CMD_LOAD, CMD_ITEM, CMD_MEM_CAP, CMD_RDX, CMD_RDY,
    CMD_EXEC, CMD_CLS, CMD_DRAW_RD, CMD_DRAW_WR, CMD_DRAW_FLAG, CMD_BCD,
    CMD_STORE, CMD_LOAD_RD, CMD_LOAD_WR, CMD_FINISH
  } cmd_e;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [15:0] instruction;
    logic [15:0] keys;
    logic [7:0]  random_byte;
    logic [11:0] address;
    logic [7:0]  write_data;
    logic [4:0]  row_select;
  } req_t;

  typedef struct packed {
    logic [11:0] program_counter;
    logic [15:0] index_value;
    logic [7:0]  read_byte;
    logic [63:0] display_row;
    logic        sound_on;
    logic        waiting_key;
  } rsp_t;

  typedef struct packed {
    cmd_e cmd;
  } ctl_t;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [15:0] instruction;
    logic [3:0]  cnt;
    logic        clr_done;
    logic        out_busy;
  } sts_t;

  localparam logic [7:0] FONT_GLYPHS [FONT_BYTES] = '{
    8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
    8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
    8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
  };

  // Reset content of main memory at one address.
  function automatic logic [7:0] font_byte(input logic [ADDR_W-1:0] a);
    logic [ADDR_W-1:0] off;
    logic [7:0]        res;
    off = a - FONT_BASE;
    res = 8'h00;
    if (a >= FONT_BASE && a < FONT_BASE + ADDR_W'(FONT_BYTES)) begin
      res = FONT_GLYPHS[off[6:0]];
    end
    return res;
  endfunction

endpackage

// File: hw/rtl/c8x_chan_if.sv
// ----------------------------------------------------------------------------
// c8x_chan_if
// Valid/ready channel carrying one payload per request.
// ----------------------------------------------------------------------------
interface c8x_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/c8x_ctrl.sv
// ----------------------------------------------------------------------------
// c8x_ctrl
// Sequencer: decodes the current request and steps the datapath.
// ----------------------------------------------------------------------------
module c8x_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  output logic               req_ready_o,
  input  c8x_pkg::sts_t      sts_i,
  output c8x_pkg::ctl_t      ctl_o
);

  c8x_pkg::st_e state_q, state_d;
  c8x_pkg::op_e op;
  logic [11:0]  nnn;
  logic [7:0]   kk;
  logic [3:0]   n;
  logic [3:0]   x;
  logic         is_exec;

  assign op      = c8x_pkg::op_e'(sts_i.instruction[15:12]);
  assign nnn     = sts_i.instruction[11:0];
  assign kk      = sts_i.instruction[7:0];
  assign n       = sts_i.instruction[3:0];
  assign x       = sts_i.instruction[11:8];
  assign is_exec = (sts_i.opcode == c8x_pkg::ITEM_EXEC);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= c8x_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      c8x_pkg::ST_CLEAR: begin
        if (sts_i.clr_done) state_d = c8x_pkg::ST_IDLE;
      end
      c8x_pkg::ST_IDLE: begin
        if (req_valid_i) state_d = c8x_pkg::ST_ITEM;
      end
      c8x_pkg::ST_ITEM: begin
        if (is_exec) begin
          state_d = c8x_pkg::ST_RDX;
        end else if (sts_i.opcode == c8x_pkg::ITEM_READ) begin
          state_d = c8x_pkg::ST_MEM_CAP;
        end else begin
          state_d = c8x_pkg::ST_DONE;
        end
      end
      c8x_pkg::ST_MEM_CAP: state_d = c8x_pkg::ST_DONE;
      c8x_pkg::ST_RDX:     state_d = c8x_pkg::ST_RDY;
      c8x_pkg::ST_RDY:     state_d = c8x_pkg::ST_EXEC;
      c8x_pkg::ST_EXEC: begin
        state_d = c8x_pkg::ST_DONE;
        if (op == c8x_pkg::OP_SYS && nnn == c8x_pkg::SYS_CLS) begin
          state_d = c8x_pkg::ST_CLS;
        end else if (op == c8x_pkg::OP_DRW) begin
          state_d = (n == 4'd0) ? c8x_pkg::ST_DRAW_FLAG : c8x_pkg::ST_DRAW_RD;
        end else if (op == c8x_pkg::OP_MISC && kk == c8x_pkg::FX_BCD) begin
          state_d = c8x_pkg::ST_BCD;
        end else if (op == c8x_pkg::OP_MISC && kk == c8x_pkg::FX_STORE) begin
          state_d = c8x_pkg::ST_STORE;
        end else if (op == c8x_pkg::OP_MISC && kk == c8x_pkg::FX_LOAD) begin
          state_d = c8x_pkg::ST_LOAD_RD;
        end
      end
      c8x_pkg::ST_CLS:     state_d = c8x_pkg::ST_DONE;
      c8x_pkg::ST_DRAW_RD: state_d = c8x_pkg::ST_DRAW_WR;
      c8x_pkg::ST_DRAW_WR: begin
        state_d = (sts_i.cnt == n - 4'd1) ? c8x_pkg::ST_DRAW_FLAG : c8x_pkg::ST_DRAW_RD;
      end
      c8x_pkg::ST_DRAW_FLAG: state_d = c8x_pkg::ST_DONE;
      c8x_pkg::ST_BCD: begin
        if (sts_i.cnt == 4'd2) state_d = c8x_pkg::ST_DONE;
      end
      c8x_pkg::ST_STORE: begin
        if (sts_i.cnt == x) state_d = c8x_pkg::ST_DONE;
      end
      c8x_pkg::ST_LOAD_RD: state_d = c8x_pkg::ST_LOAD_WR;
      c8x_pkg::ST_LOAD_WR: begin
        state_d = (sts_i.cnt == x) ? c8x_pkg::ST_DONE : c8x_pkg::ST_LOAD_RD;
      end
      c8x_pkg::ST_DONE: begin
        if (!sts_i.out_busy) state_d = c8x_pkg::ST_IDLE;
      end
      default: state_d = c8x_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    req_ready_o = 1'b0;
    ctl_o.cmd   = c8x_pkg::CMD_NONE;
    unique case (state_q)
      c8x_pkg::ST_CLEAR: ctl_o.cmd = c8x_pkg::CMD_CLEAR;
      c8x_pkg::ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) ctl_o.cmd = c8x_pkg::CMD_LOAD;
      end
      c8x_pkg::ST_ITEM: begin
        ctl_o.cmd = is_exec ? c8x_pkg::CMD_NONE : c8x_pkg::CMD_ITEM;
      end
      c8x_pkg::ST_MEM_CAP:   ctl_o.cmd = c8x_pkg::CMD_MEM_CAP;
      c8x_pkg::ST_RDX:       ctl_o.cmd = c8x_pkg::CMD_RDX;
      c8x_pkg::ST_RDY:       ctl_o.cmd = c8x_pkg::CMD_RDY;
      c8x_pkg::ST_EXEC:      ctl_o.cmd = c8x_pkg::CMD_EXEC;
      c8x_pkg::ST_CLS:       ctl_o.cmd = c8x_pkg::CMD_CLS;
      c8x_pkg::ST_DRAW_RD:   ctl_o.cmd = c8x_pkg::CMD_DRAW_RD;
      c8x_pkg::ST_DRAW_WR:   ctl_o.cmd = c8x_pkg::CMD_DRAW_WR;
      c8x_pkg::ST_DRAW_FLAG: ctl_o.cmd = c8x_pkg::CMD_DRAW_FLAG;
      c8x_pkg::ST_BCD:       ctl_o.cmd = c8x_pkg::CMD_BCD;
      c8x_pkg::ST_STORE:     ctl_o.cmd = c8x_pkg::CMD_STORE;
      c8x_pkg::ST_LOAD_RD:   ctl_o.cmd = c8x_pkg::CMD_LOAD_RD;
      c8x_pkg::ST_LOAD_WR:   ctl_o.cmd = c8x_pkg::CMD_LOAD_WR;
      c8x_pkg::ST_DONE: begin
        if (!sts_i.out_busy) ctl_o.cmd = c8x_pkg::CMD_FINISH;
      end
      default: ctl_o.cmd = c8x_pkg::CMD_NONE;
    endcase
  end

endmodule

// File: hw/rtl/c8x_datapath.sv
// ----------------------------------------------------------------------------
// c8x_datapath
// Architectural state, main memory, frame buffer and result register.
// ----------------------------------------------------------------------------
module c8x_datapath #(
  parameter int unsigned StackDepth = c8x_pkg::STACK_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  c8x_pkg::ctl_t       ctl_i,
  output c8x_pkg::sts_t       sts_o,
  input  c8x_pkg::req_t       req_data_i,
  input  logic                cfg_we_i,
  input  logic [11:0]         cfg_data_i,
  input  logic                rsp_ready_i,
  output logic                rsp_valid_o,
  output c8x_pkg::rsp_t       rsp_data_o
);

  localparam int unsigned     SpW    = $clog2(StackDepth);
  localparam logic [SpW-1:0]  SpLast = SpW'(StackDepth - 1);

  c8x_pkg::req_t req_q, req_d;
  c8x_pkg::rsp_t out_q, out_d;
  logic          out_vld_q, out_vld_d;
  logic [11:0]   pc_q, pc_d, pstart_q, pstart_d, clr_q, clr_d;
  logic [15:0]   idx_q, idx_d;
  logic [SpW-1:0] sp_q, sp_d;
  logic [7:0]    dly_q, dly_d, snd_q, snd_d, a_q, a_d, b_q, b_d, rd_q, rd_d;
  logic [3:0]    cnt_q, cnt_d;
  logic          hit_q, hit_d, wait_q, wait_d;
  logic [63:0]   row_q, row_d;
  logic [11:0]   bcd_q, bcd_d;

  logic [7:0]    vreg_q [c8x_pkg::NUM_VREGS];
  logic [11:0]   stk_q  [StackDepth];
  logic [63:0]   frm_q  [c8x_pkg::SCREEN_H];
  logic [7:0]    mem    [c8x_pkg::MEM_BYTES];
  logic [7:0]    mem_rdata_q;

  logic          rf_we, vf_we, stk_we, frm_we, frm_clr, mem_we;
  logic [3:0]    rf_wa, rf_ra;
  logic [7:0]    rf_wd, vf_wd, v_rd, mem_wd;
  logic [11:0]   mem_wa, mem_ra, i_off;
  logic [4:0]    frm_ra;
  logic [63:0]   frm_rd, frm_wd, mask;
  logic [127:0]  mask_dbl;
  logic [SpW-1:0] sp_inc, sp_dec;

  c8x_pkg::op_e  op;
  logic [3:0]    x, y, n;
  logic [7:0]    kk;
  logic [11:0]   nnn;

  logic [7:0]    alu_res;
  logic          alu_flag, alu_has_flag, alu_ok;
  logic [8:0]    sum9;
  logic [3:0]    key_low;
  logic [1:0]    hund;
  logic [7:0]    hund100, rem8;
  logic [14:0]   prod;
  logic [3:0]    tens;
  logic [6:0]    ones;
  logic          pressed;

  assign op  = c8x_pkg::op_e'(req_q.instruction[15:12]);
  assign x   = req_q.instruction[11:8];
  assign y   = req_q.instruction[7:4];
  assign n   = req_q.instruction[3:0];
  assign kk  = req_q.instruction[7:0];
  assign nnn = req_q.instruction[11:0];

  assign sp_inc = (sp_q == SpLast) ? '0 : sp_q + SpW'(1);
  assign sp_dec = (sp_q == '0) ? SpLast : sp_q - SpW'(1);
  assign i_off  = idx_q[11:0] + {8'h00, cnt_q};

  always_comb begin
    unique case (ctl_i.cmd)
      c8x_pkg::CMD_RDX: rf_ra = x;
      c8x_pkg::CMD_RDY: rf_ra = (op == c8x_pkg::OP_JPV) ? 4'd0 : y;
      default:          rf_ra = cnt_q;
    endcase
  end
  assign v_rd = vreg_q[rf_ra];

  assign frm_ra = (ctl_i.cmd == c8x_pkg::CMD_DRAW_WR) ? 5'(b_q[4:0] + {1'b0, cnt_q})
                                                      : req_q.row_select;
  assign frm_rd   = frm_q[frm_ra];
  assign mask_dbl = {mem_rdata_q, 56'h0, mem_rdata_q, 56'h0} >> a_q[5:0];
  assign mask     = mask_dbl[63:0];

  assign sum9 = {1'b0, a_q} + {1'b0, b_q};
  always_comb begin
    alu_res      = a_q;
    alu_flag     = 1'b0;
    alu_has_flag = 1'b1;
    alu_ok       = 1'b1;
    unique case (n)
      c8x_pkg::ALU_LD:  begin alu_res = b_q;         alu_has_flag = 1'b0; end
      c8x_pkg::ALU_OR:  begin alu_res = a_q | b_q;   alu_has_flag = 1'b0; end
      c8x_pkg::ALU_AND: begin alu_res = a_q & b_q;   alu_has_flag = 1'b0; end
      c8x_pkg::ALU_XOR: begin alu_res = a_q ^ b_q;   alu_has_flag = 1'b0; end
      c8x_pkg::ALU_ADD: begin alu_res = sum9[7:0];   alu_flag = sum9[8]; end
      c8x_pkg::ALU_SUB: begin alu_res = a_q - b_q;   alu_flag = (a_q >= b_q); end
      c8x_pkg::ALU_SHR: begin alu_res = a_q >> 1;    alu_flag = a_q[0]; end
      c8x_pkg::ALU_SBN: begin alu_res = b_q - a_q;   alu_flag = (b_q >= a_q); end
      c8x_pkg::ALU_SHL: begin alu_res = a_q << 1;    alu_flag = a_q[7]; end
      default: begin alu_ok = 1'b0; alu_has_flag = 1'b0; end
    endcase
  end

  always_comb begin
    key_low = 4'd0;
    for (int i = 15; i >= 0; i--) begin
      if (req_q.keys[i]) key_low = 4'(i);
    end
  end
  assign pressed = req_q.keys[a_q[3:0]];

  // Decimal digits: hundreds by compare, tens by reciprocal multiply.
  always_comb begin
    if (a_q >= 8'd200) begin
      hund = 2'd2; hund100 = 8'd200;
    end else if (a_q >= 8'd100) begin
      hund = 2'd1; hund100 = 8'd100;
    end else begin
      hund = 2'd0; hund100 = 8'd0;
    end
  end
  assign rem8 = a_q - hund100;
  assign prod = 15'(rem8[6:0]) * 15'd205;
  assign tens = prod[14:11];
  assign ones = rem8[6:0] - {tens, 3'b000} - {2'b00, tens, 1'b0};

  always_comb begin
    req_d     = req_q;
    out_d     = out_q;
    out_vld_d = out_vld_q & ~rsp_ready_i;
    pc_d      = pc_q;
    pstart_d  = pstart_q;
    clr_d     = clr_q;
    idx_d     = idx_q;
    sp_d      = sp_q;
    dly_d     = dly_q;
    snd_d     = snd_q;
    a_d       = a_q;
    b_d       = b_q;
    rd_d      = rd_q;
    cnt_d     = cnt_q;
    hit_d     = hit_q;
    wait_d    = wait_q;
    row_d     = row_q;
    bcd_d     = bcd_q;
    rf_we     = 1'b0;
    rf_wa     = x;
    rf_wd     = alu_res;
    vf_we     = 1'b0;
    vf_wd     = {7'd0, alu_flag};
    stk_we    = 1'b0;
    frm_we    = 1'b0;
    frm_clr   = 1'b0;
    frm_wd    = frm_rd ^ mask;
    mem_we    = 1'b0;
    mem_wa    = i_off;
    mem_wd    = v_rd;
    mem_ra    = i_off;

    unique case (ctl_i.cmd)
      c8x_pkg::CMD_NONE: ;
      c8x_pkg::CMD_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_q;
        mem_wd = c8x_pkg::font_byte(clr_q);
        clr_d  = clr_q + 12'd1;
      end
      c8x_pkg::CMD_LOAD: begin
        req_d  = req_data_i;
        rd_d   = 8'h00;
        row_d  = 64'h0;
        wait_d = 1'b0;
      end
      c8x_pkg::CMD_ITEM: begin
        priority if (req_q.opcode == c8x_pkg::ITEM_WRITE) begin
          mem_we = 1'b1;
          mem_wa = req_q.address;
          mem_wd = req_q.write_data;
        end else if (req_q.opcode == c8x_pkg::ITEM_READ) begin
          mem_ra = req_q.address;
        end else if (req_q.opcode == c8x_pkg::ITEM_ROW) begin
          row_d = frm_rd;
        end else if (req_q.opcode == c8x_pkg::ITEM_TICK) begin
          if (dly_q != 8'h00) dly_d = dly_q - 8'd1;
          if (snd_q != 8'h00) snd_d = snd_q - 8'd1;
        end else begin
          // unused selector: result reports the state only
        end
      end
      c8x_pkg::CMD_MEM_CAP: rd_d = mem_rdata_q;
      c8x_pkg::CMD_RDX: begin
        a_d  = v_rd;
        pc_d = pc_q + c8x_pkg::PC_STEP;
      end
      c8x_pkg::CMD_RDY: begin
        b_d   = v_rd;
        cnt_d = 4'd0;
        hit_d = 1'b0;
      end
      c8x_pkg::CMD_EXEC: begin
        unique case (op)
          c8x_pkg::OP_SYS: begin
            if (nnn == c8x_pkg::SYS_RET) begin
              sp_d = sp_dec;
              pc_d = stk_q[sp_dec];
            end
          end
          c8x_pkg::OP_JP: pc_d = nnn;
          c8x_pkg::OP_CALL: begin
            stk_we = 1'b1;
            sp_d   = sp_inc;
            pc_d   = nnn;
          end
          c8x_pkg::OP_SE:  if (a_q == kk) pc_d = pc_q + c8x_pkg::PC_STEP;
          c8x_pkg::OP_SNE: if (a_q != kk) pc_d = pc_q + c8x_pkg::PC_STEP;
          c8x_pkg::OP_SER: begin
            if (n == 4'd0 && a_q == b_q) pc_d = pc_q + c8x_pkg::PC_STEP;
          end
          c8x_pkg::OP_SNER: begin
            if (n == 4'd0 && a_q != b_q) pc_d = pc_q + c8x_pkg::PC_STEP;
          end
          c8x_pkg::OP_LD: begin
            rf_we = 1'b1;
            rf_wd = kk;
          end
          c8x_pkg::OP_ADD: begin
            rf_we = 1'b1;
            rf_wd = a_q + kk;
          end
          c8x_pkg::OP_ALU: begin
            rf_we = alu_ok;
            vf_we = alu_has_flag;
          end
          c8x_pkg::OP_LDI: idx_d = {4'h0, nnn};
          c8x_pkg::OP_JPV: pc_d = {4'h0, b_q} + nnn;
          c8x_pkg::OP_RND: begin
            rf_we = 1'b1;
            rf_wd = req_q.random_byte & kk;
          end
          c8x_pkg::OP_DRW: ;
          c8x_pkg::OP_KEY: begin
            if ((kk == c8x_pkg::KEY_SKP && pressed) ||
                (kk == c8x_pkg::KEY_SKNP && !pressed)) begin
              pc_d = pc_q + c8x_pkg::PC_STEP;
            end
          end
          c8x_pkg::OP_MISC: begin
            priority case (kk)
              c8x_pkg::FX_LDDT: begin
                rf_we = 1'b1;
                rf_wd = dly_q;
              end
              c8x_pkg::FX_WKEY: begin
                if (req_q.keys != 16'h0) begin
                  rf_we = 1'b1;
                  rf_wd = {4'h0, key_low};
                end else begin
                  pc_d   = pc_q - c8x_pkg::PC_STEP;
                  wait_d = 1'b1;
                end
              end
              c8x_pkg::FX_SETDT: dly_d = a_q;
              c8x_pkg::FX_SETST: snd_d = a_q;
              c8x_pkg::FX_ADDI:  idx_d = idx_q + {8'h00, a_q};
              c8x_pkg::FX_FONT: begin
                idx_d = {4'h0, c8x_pkg::FONT_BASE} + {10'd0, a_q[3:0], 2'b00}
                        + {12'd0, a_q[3:0]};
              end
              c8x_pkg::FX_BCD: bcd_d = {2'b00, hund, tens, ones[3:0]};
              default: ;
            endcase
          end
          default: ;
        endcase
      end
      c8x_pkg::CMD_CLS:     frm_clr = 1'b1;
      c8x_pkg::CMD_DRAW_RD: ;
      c8x_pkg::CMD_DRAW_WR: begin
        frm_we = 1'b1;
        hit_d  = hit_q | (|(frm_rd & mask));
        cnt_d  = cnt_q + 4'd1;
      end
      c8x_pkg::CMD_DRAW_FLAG: begin
        vf_we = 1'b1;
        vf_wd = {7'd0, hit_q};
      end
      c8x_pkg::CMD_BCD: begin
        mem_we = 1'b1;
        unique case (cnt_q[1:0])
          2'd0:    mem_wd = {4'h0, bcd_q[11:8]};
          2'd1:    mem_wd = {4'h0, bcd_q[7:4]};
          default: mem_wd = {4'h0, bcd_q[3:0]};
        endcase
        cnt_d = cnt_q + 4'd1;
      end
      c8x_pkg::CMD_STORE: begin
        mem_we = 1'b1;
        cnt_d  = cnt_q + 4'd1;
      end
      c8x_pkg::CMD_LOAD_RD: ;
      c8x_pkg::CMD_LOAD_WR: begin
        rf_we = 1'b1;
        rf_wa = cnt_q;
        rf_wd = mem_rdata_q;
        cnt_d = cnt_q + 4'd1;
      end
      c8x_pkg::CMD_FINISH: begin
        out_vld_d             = 1'b1;
        out_d.program_counter = pc_q;
        out_d.index_value     = idx_q;
        out_d.read_byte       = rd_q;
        out_d.display_row     = row_q;
        out_d.sound_on        = |snd_q;
        out_d.waiting_key     = wait_q;
      end
      default: ;
    endcase

    if (cfg_we_i) begin
      pstart_d = cfg_data_i;
      pc_d     = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      pc_q      <= c8x_pkg::PROG_START_RST;
      pstart_q  <= c8x_pkg::PROG_START_RST;
      clr_q     <= 12'd0;
      idx_q     <= 16'h0;
      sp_q      <= '0;
      dly_q     <= 8'h00;
      snd_q     <= 8'h00;
    end else begin
      out_vld_q <= out_vld_d;
      pc_q      <= pc_d;
      pstart_q  <= pstart_d;
      clr_q     <= clr_d;
      idx_q     <= idx_d;
      sp_q      <= sp_d;
      dly_q     <= dly_d;
      snd_q     <= snd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    out_q  <= out_d;
    a_q    <= a_d;
    b_q    <= b_d;
    rd_q   <= rd_d;
    cnt_q  <= cnt_d;
    hit_q  <= hit_d;
    wait_q <= wait_d;
    row_q  <= row_d;
    bcd_q  <= bcd_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < c8x_pkg::NUM_VREGS; i++) vreg_q[i] <= 8'h00;
    end else begin
      if (rf_we) vreg_q[rf_wa] <= rf_wd;
      if (vf_we) vreg_q[c8x_pkg::NUM_VREGS-1] <= vf_wd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < StackDepth; i++) stk_q[i] <= 12'h000;
    end else if (stk_we) begin
      stk_q[sp_q] <= pc_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < c8x_pkg::SCREEN_H; i++) frm_q[i] <= 64'h0;
    end else if (frm_clr) begin
      for (int i = 0; i < c8x_pkg::SCREEN_H; i++) frm_q[i] <= 64'h0;
    end else if (frm_we) begin
      frm_q[frm_ra] <= frm_wd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    mem_rdata_q <= mem[mem_ra];
  end

  assign sts_o.opcode      = req_q.opcode;
  assign sts_o.instruction = req_q.instruction;
  assign sts_o.cnt         = cnt_q;
  assign sts_o.clr_done    = &clr_q;
  assign sts_o.out_busy    = out_vld_q & ~rsp_ready_i;

  assign rsp_valid_o = out_vld_q;
  assign rsp_data_o  = out_q;

endmodule

// File: hw/rtl/chip8_instruction_execute.sv
// ----------------------------------------------------------------------------
// chip8_instruction_execute
// CHIP-8 core: executes instructions, loads and reads memory, returns display
// rows and applies timer ticks, one response per request.
//
//   channel  dir  payload            handshake
//   req_i    in   c8x_pkg::req_t     valid/ready
//   rsp_o    out  c8x_pkg::rsp_t     valid/ready
//   cfg_i    in   program_start[11:0] valid/ready (always ready)
//
// Requests run one at a time; the next one is taken only after the current
// one has finished. A sprite draw does one memory row read per line, and a
// response waiting at rsp_o adds stall.
// After reset, all 4096 bytes of main memory are initialized (font at 0x50)
// before the first request is taken.
// ----------------------------------------------------------------------------
module chip8_instruction_execute #(
  parameter int unsigned StackDepth = c8x_pkg::STACK_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  c8x_chan_if.sink   req_i,
  c8x_chan_if.source rsp_o,
  c8x_chan_if.sink   cfg_i
);

  c8x_pkg::ctl_t ctl;
  c8x_pkg::sts_t sts;
  c8x_pkg::rsp_t rsp_data;
  logic          rsp_valid;

  assign cfg_i.ready = 1'b1;

  c8x_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .sts_i       (sts),
    .ctl_o       (ctl)
  );

  c8x_datapath #(
    .StackDepth (StackDepth)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .sts_o       (sts),
    .req_data_i  (req_i.data),
    .cfg_we_i    (cfg_i.valid),
    .cfg_data_i  (cfg_i.data),
    .rsp_ready_i (rsp_o.ready),
    .rsp_valid_o (rsp_valid),
    .rsp_data_o  (rsp_data)
  );

  assign rsp_o.valid = rsp_valid;
  assign rsp_o.data  = rsp_data;

endmodule

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the CHIP-8 execute core: directed and random
// requests, compared field by field against an in-bench core model.
// ----------------------------------------------------------------------------
class c8_scoreboard;
  logic [11:0] prog_start;
  logic [7:0]  vreg [16];
  logic [7:0]  mem [4096];
  logic [11:0] stk [16];
  logic [3:0]  sp;
  logic [63:0] frame [32];
  logic [15:0] idx;
  logic [11:0] pc;
  logic [7:0]  dt, st;
  c8x_pkg::rsp_t pending[$];
  int errors;

  function new();
    errors = 0;
    prog_start = c8x_pkg::PROG_START_RST;
    foreach (vreg[i]) vreg[i] = '0;
    foreach (mem[i]) mem[i] = '0;
    for (int i = 0; i < 80; i++) mem[80 + i] = c8x_pkg::FONT_GLYPHS[i];
    foreach (stk[i]) stk[i] = '0;
    foreach (frame[i]) frame[i] = '0;
    sp = 0; idx = 0; pc = prog_start; dt = 0; st = 0;
  endfunction

  function void set_start(logic [11:0] v);
    prog_start = v;
    pc = v;
  endfunction

  function void skip(bit c);
    if (c) pc = pc + 12'd2;
  endfunction

  function bit exec_instr(logic [15:0] w, logic [15:0] keys, logic [7:0] rnd);
    logic [3:0] x, y, n;
    logic [7:0] kk, a, b, res, v;
    logic       flag;
    logic [8:0] s;
    logic [5:0] xp, col;
    logic [4:0] yp, row;
    logic [7:0] bits;
    bit hit, hasf;
    x = w[11:8]; y = w[7:4]; n = w[3:0]; kk = w[7:0];
    pc = pc + 12'd2;
    case (c8x_pkg::op_e'(w[15:12]))
      c8x_pkg::OP_SYS: begin
        if (w[11:0] == c8x_pkg::SYS_CLS) foreach (frame[i]) frame[i] = '0;
        else if (w[11:0] == c8x_pkg::SYS_RET) begin
          sp = sp - 4'd1;
          pc = stk[sp];
        end
      end
      c8x_pkg::OP_JP: pc = w[11:0];
      c8x_pkg::OP_CALL: begin
        stk[sp] = pc;
        sp = sp + 4'd1;
        pc = w[11:0];
      end
      c8x_pkg::OP_SE: skip(vreg[x] == kk);
      c8x_pkg::OP_SNE: skip(vreg[x] != kk);
      c8x_pkg::OP_SER: if (n == 0) skip(vreg[x] == vreg[y]);
      c8x_pkg::OP_LD: vreg[x] = kk;
      c8x_pkg::OP_ADD: vreg[x] = vreg[x] + kk;
      c8x_pkg::OP_ALU: begin
        a = vreg[x]; b = vreg[y]; flag = 1'b0; hasf = 1; res = a;
        case (n)
          c8x_pkg::ALU_LD: begin res = b; hasf = 0; end
          c8x_pkg::ALU_OR: begin res = a | b; hasf = 0; end
          c8x_pkg::ALU_AND: begin res = a & b; hasf = 0; end
          c8x_pkg::ALU_XOR: begin res = a ^ b; hasf = 0; end
          c8x_pkg::ALU_ADD: begin s = a + b; res = s[7:0]; flag = s[8]; end
          c8x_pkg::ALU_SUB: begin res = a - b; flag = (a >= b); end
          c8x_pkg::ALU_SHR: begin res = a >> 1; flag = a[0]; end
          c8x_pkg::ALU_SBN: begin res = b - a; flag = (b >= a); end
          c8x_pkg::ALU_SHL: begin res = a << 1; flag = a[7]; end
          default: return 0;
        endcase
        vreg[x] = res;
        if (hasf) vreg[15] = {7'd0, flag};
      end
      c8x_pkg::OP_SNER: if (n == 0) skip(vreg[x] != vreg[y]);
      c8x_pkg::OP_LDI: idx = {4'h0, w[11:0]};
      c8x_pkg::OP_JPV: pc = {4'h0, vreg[0]} + w[11:0];
      c8x_pkg::OP_RND: vreg[x] = rnd & kk;
      c8x_pkg::OP_DRW: begin
        xp = vreg[x][5:0]; yp = vreg[y][4:0]; hit = 0;
        for (int r = 0; r < n; r++) begin
          bits = mem[12'(idx + r)];
          row = 5'(yp + r);
          for (int c = 0; c < 8; c++) if (bits[7-c]) begin
            col = 6'(xp + c);
            if (frame[row][63-col]) hit = 1;
            frame[row][63-col] = ~frame[row][63-col];
          end
        end
        vreg[15] = {7'd0, hit};
      end
      c8x_pkg::OP_KEY: begin
        if (kk == c8x_pkg::KEY_SKP) skip(keys[vreg[x][3:0]]);
        else if (kk == c8x_pkg::KEY_SKNP) skip(!keys[vreg[x][3:0]]);
      end
      default: begin
        case (kk)
          c8x_pkg::FX_LDDT: vreg[x] = dt;
          c8x_pkg::FX_WKEY: begin
            for (int i = 0; i < 16; i++) if (keys[i]) begin
              vreg[x] = 8'(i);
              return 0;
            end
            pc = pc - 12'd2;
            return 1;
          end
          c8x_pkg::FX_SETDT: dt = vreg[x];
          c8x_pkg::FX_SETST: st = vreg[x];
          c8x_pkg::FX_ADDI: idx = idx + {8'h00, vreg[x]};
          c8x_pkg::FX_FONT: idx = 16'h0050 + 16'd5 * {12'h000, vreg[x][3:0]};
          c8x_pkg::FX_BCD: begin
            v = vreg[x];
            mem[idx[11:0]] = v / 8'd100;
            mem[12'(idx + 1)] = (v / 8'd10) % 8'd10;
            mem[12'(idx + 2)] = v % 8'd10;
          end
          c8x_pkg::FX_STORE: for (int i = 0; i <= x; i++) mem[12'(idx + i)] = vreg[i];
          c8x_pkg::FX_LOAD: for (int i = 0; i <= x; i++) vreg[i] = mem[12'(idx + i)];
          default: ;
        endcase
      end
    endcase
    return 0;
  endfunction

  function void note_request(c8x_pkg::req_t q);
    c8x_pkg::rsp_t e;
    e = '0;
    case (q.opcode)
      c8x_pkg::ITEM_EXEC: e.waiting_key = exec_instr(q.instruction, q.keys, q.random_byte);
      c8x_pkg::ITEM_WRITE: mem[q.address] = q.write_data;
      c8x_pkg::ITEM_READ: e.read_byte = mem[q.address];
      c8x_pkg::ITEM_ROW: e.display_row = frame[q.row_select];
      c8x_pkg::ITEM_TICK: begin
        if (dt != 0) dt--;
        if (st != 0) st--;
      end
      default: ;
    endcase
    e.program_counter = pc;
    e.index_value = idx;
    e.sound_on = (st != 0);
    pending.push_back(e);
  endfunction

  task report(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH %s: got %h want %h", what, got, want);
    errors++;
  endtask

  task check_response(c8x_pkg::rsp_t r);
    c8x_pkg::rsp_t e;
    if (pending.size() == 0) begin
      report("unexpected response", 64'(r.program_counter), 64'd0);
      return;
    end
    e = pending.pop_front();
    if (r.program_counter !== e.program_counter)
      report("program_counter", 64'(r.program_counter), 64'(e.program_counter));
    if (r.index_value !== e.index_value)
      report("index_value", 64'(r.index_value), 64'(e.index_value));
    if (r.read_byte !== e.read_byte)
      report("read_byte", 64'(r.read_byte), 64'(e.read_byte));
    if (r.display_row !== e.display_row) report("display_row", r.display_row, e.display_row);
    if (r.sound_on !== e.sound_on) report("sound_on", 64'(r.sound_on), 64'(e.sound_on));
    if (r.waiting_key !== e.waiting_key)
      report("waiting_key", 64'(r.waiting_key), 64'(e.waiting_key));
  endtask
endclass

module tb_top;

  logic clk_i = 0;
  logic rst_ni = 0;
  c8x_chan_if #(.T(c8x_pkg::req_t)) req_ch ();
  c8x_chan_if #(.T(c8x_pkg::rsp_t)) rsp_ch ();
  c8x_chan_if #(.T(logic [11:0])) cfg_ch ();

  chip8_instruction_execute dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .req_i(req_ch), .rsp_o(rsp_ch), .cfg_i(cfg_ch)
  );

  always begin
    #2 clk_i = 1;
    #2 clk_i = 0;
  end

  c8_scoreboard sb = new();
  int send_idle_pct, stall_pct, hold_cycles, idle_count;
  bit done;

  initial begin
    req_ch.valid = 0; req_ch.data = '0;
    cfg_ch.valid = 0; cfg_ch.data = '0;
    rsp_ch.ready = 0;
    send_idle_pct = 0; stall_pct = 0; hold_cycles = 0; done = 0; idle_count = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1;
  end

  // response side
  always @(posedge clk_i) if (rst_ni) begin
    if (rsp_ch.valid && rsp_ch.ready) sb.check_response(rsp_ch.data);
  end
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      rsp_ch.ready <= 0;
    end else rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
        || !rst_ni || done) idle_count <= 0;
    else idle_count <= idle_count + 1;
    if (idle_count > 20000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // valid stays high after the last request until the next send or drain
  task automatic send(c8x_pkg::req_t q);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 0;
      @(negedge clk_i);
    end
    req_ch.data <= q;
    req_ch.valid <= 1;
    do @(posedge clk_i); while (!req_ch.ready);
    sb.note_request(q);
    @(negedge clk_i);
  endtask

  task automatic drain();
    req_ch.valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
  endtask

  task automatic write_start(logic [11:0] v);
    cfg_ch.data <= v;
    cfg_ch.valid <= 1;
    do @(posedge clk_i); while (!cfg_ch.ready);
    sb.set_start(v);
    @(negedge clk_i);
    cfg_ch.valid <= 0;
  endtask

  function automatic c8x_pkg::req_t mk(c8x_pkg::item_e op, logic [15:0] w);
    c8x_pkg::req_t q;
    q = '0;
    q.opcode = op;
    q.instruction = w;
    q.keys = 16'($urandom);
    q.random_byte = 8'($urandom);
    q.address = 12'($urandom);
    q.write_data = 8'($urandom);
    q.row_select = 5'($urandom);
    return q;
  endfunction

  function automatic logic [15:0] rand_instr();
    logic [15:0] w;
    logic [7:0] fx [9];
    fx = '{c8x_pkg::FX_LDDT, c8x_pkg::FX_WKEY, c8x_pkg::FX_SETDT, c8x_pkg::FX_SETST,
           c8x_pkg::FX_ADDI, c8x_pkg::FX_FONT, c8x_pkg::FX_BCD, c8x_pkg::FX_STORE,
           c8x_pkg::FX_LOAD};
    w = 16'($urandom);
    case ($urandom_range(9))
      0: w = {c8x_pkg::OP_ALU, w[11:4],
              ($urandom_range(8) == 8) ? c8x_pkg::ALU_SHL : 4'($urandom_range(7))};
      1: w = {c8x_pkg::OP_MISC, w[11:8], fx[$urandom_range(8)]};
      2: w = {c8x_pkg::OP_DRW, w[11:4], 4'($urandom_range(4))};
      3: w = {c8x_pkg::OP_KEY, w[11:8],
              $urandom_range(1) ? c8x_pkg::KEY_SKP : c8x_pkg::KEY_SKNP};
      4: w = {c8x_pkg::OP_SYS, $urandom_range(1) ? c8x_pkg::SYS_RET : c8x_pkg::SYS_CLS};
      5: w = {c8x_pkg::OP_LD, w[11:0]};
      default: ;
    endcase
    return w;
  endfunction

  function automatic c8x_pkg::req_t rand_req();
    c8x_pkg::req_t q;
    int p;
    p = $urandom_range(99);
    if (p < 60) q = mk(c8x_pkg::ITEM_EXEC, rand_instr());
    else if (p < 70) q = mk(c8x_pkg::ITEM_WRITE, 16'($urandom));
    else if (p < 80) q = mk(c8x_pkg::ITEM_READ, 16'($urandom));
    else if (p < 88) q = mk(c8x_pkg::ITEM_ROW, 16'($urandom));
    else if (p < 97) q = mk(c8x_pkg::ITEM_TICK, 16'($urandom));
    else q = mk(c8x_pkg::item_e'(3'($urandom_range(7, 5))), 16'($urandom));
    if ($urandom_range(9) == 0) q.keys = 16'h0000;
    return q;
  endfunction

  initial begin
    c8x_pkg::req_t q;
    logic [15:0] dir [25];
    @(posedge rst_ni);
    @(negedge clk_i);
    write_start(12'hFFE);
    dir = '{16'h60FF, 16'h61FF, 16'h8014, 16'h8015, 16'h8117, 16'h8016, 16'h801E,
            16'hA000, 16'hF033, 16'hFF55, 16'hF065, 16'hF029, 16'hD0F5, 16'hDEEF,
            16'h2FFF, 16'h00EE, 16'h00EE, 16'hB0FF, 16'hF018, 16'hF015, 16'hF00A,
            16'h5011, 16'h9010, 16'hAFFF, 16'hFF1E};
    foreach (dir[i]) begin
      q = mk(c8x_pkg::ITEM_EXEC, dir[i]);
      q.keys = (dir[i] == 16'hF00A) ? 16'h0000 : 16'h8000;
      send(q);
    end
    q = mk(c8x_pkg::ITEM_WRITE, 16'h0000); q.address = 12'hFFF; q.write_data = 8'hFF;
    send(q);
    q = mk(c8x_pkg::ITEM_READ, 16'h0000); q.address = 12'hFFF; send(q);
    q = mk(c8x_pkg::ITEM_ROW, 16'h0000); q.row_select = 5'd31; send(q);
    q = mk(c8x_pkg::ITEM_TICK, 16'h0000); send(q);
    drain();
    write_start(12'h000);
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0; stall_pct = 0; end
        1: begin send_idle_pct = 55; stall_pct = 0; end
        2: begin send_idle_pct = 0; stall_pct = 55; end
        3: begin send_idle_pct = 21; stall_pct = 21; end
        default: begin send_idle_pct = 0; stall_pct = 0; end
      endcase
      if (ph == 2) hold_cycles = 400;
      for (int i = 0; i < 290; i++) send(rand_req());
      drain();
      write_start(ph == 3 ? 12'hFFF : 12'($urandom));
    end
    drain();
    done = 1;
    if (sb.errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule

// File: filelist.f
hw/rtl/c8x_pkg.sv
hw/rtl/c8x_chan_if.sv
hw/rtl/c8x_ctrl.sv
hw/rtl/c8x_datapath.sv
hw/rtl/chip8_instruction_execute.sv
sim/tb_top.sv
